// ===== hdl/hsa_pkg.sv =====
package hsa_pkg;

   localparam int NUM_SOURCES = 8;
   localparam int SLOT_W      = $clog2(NUM_SOURCES);
   localparam int CNT_W       = $clog2(NUM_SOURCES + 1);
   localparam int MASK_W      = 8;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // command codes on the request channel
   localparam logic [2:0] CMD_REGISTER = 3'd0;
   localparam logic [2:0] CMD_CONNECT  = 3'd1;
   localparam logic [2:0] CMD_PARSE    = 3'd2;
   localparam logic [2:0] CMD_EVENT    = 3'd3;
   localparam logic [2:0] CMD_ARB      = 3'd4;

   // register indexes
   localparam logic [1:0] CSR_SILENCE   = 2'd0;
   localparam logic [1:0] CSR_THRESHOLD = 2'd1;
   localparam logic [1:0] CSR_PENALTY   = 2'd2;
   localparam logic [1:0] CSR_HMAX      = 2'd3;

   localparam logic [31:0] SILENCE_RESET   = 32'd3000;
   localparam logic [6:0]  THRESHOLD_RESET = 7'd50;
   localparam logic [6:0]  PENALTY_RESET   = 7'd5;
   localparam logic [6:0]  HMAX_RESET      = 7'd100;
   localparam logic [15:0] COUNT_MAX       = 16'hFFFF;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [3:0]  source_id;
      logic        flag;
      logic [7:0]  priority_req;
      logic [31:0] now_tick;
   } req_type;

   typedef struct packed {
      logic [3:0]        owner;
      logic              owner_changed;
      logic [MASK_W-1:0] eligible_mask;
      logic [15:0]       migration_count;
      logic [3:0]        entry_count;
      logic              accepted;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_REG,
      OP_CONN,
      OP_PARSE,
      OP_EVENT,
      OP_ARB,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [3:0]  source_id;
      logic        flag;
      logic [7:0]  prio;
      logic [31:0] now;
   } item_type;

   typedef struct packed {
      logic [3:0]  id;
      logic [7:0]  prio;
      logic [6:0]  health;
      logic [15:0] count;
      logic        conn;
      logic        init;
      logic        recv;
      logic        elig;
      logic [31:0] tick;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_APPLY,
      ST_DONE
   } state_type;

   // queue status seen by the front and back ends
   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

endpackage

// ===== hdl/hsa_queue.sv =====
module hsa_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  hsa_pkg::item_type  push_item,
   input  logic               pop,
   output hsa_pkg::item_type  pop_item,
   output hsa_pkg::qstat_type stat
);

   hsa_pkg::item_type                 mem_ff [hsa_pkg::QUEUE_DEPTH];
   logic [hsa_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [hsa_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [hsa_pkg::QCNT_W-1:0]        cnt_ff, cnt_in;

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item   = mem_ff[rd_ptr_ff];
   assign stat.empty = (cnt_ff == '0);
   assign stat.full  = (cnt_ff == hsa_pkg::QCNT_W'(hsa_pkg::QUEUE_DEPTH));

endmodule

// ===== hdl/hsa_front.sv =====
module hsa_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  hsa_pkg::req_type   req_data,
   output logic               busy,
   input  hsa_pkg::qstat_type qstat,
   output logic               push,
   output hsa_pkg::item_type  push_item
);

   logic              valid_ff, valid_in;
   hsa_pkg::item_type item_ff, item_in;
   logic              take;

   // command decode
   function automatic hsa_pkg::op_type decode(input logic [2:0] cmd);
      hsa_pkg::op_type op;
      unique case (cmd)
         hsa_pkg::CMD_REGISTER: op = hsa_pkg::OP_REG;
         hsa_pkg::CMD_CONNECT:  op = hsa_pkg::OP_CONN;
         hsa_pkg::CMD_PARSE:    op = hsa_pkg::OP_PARSE;
         hsa_pkg::CMD_EVENT:    op = hsa_pkg::OP_EVENT;
         hsa_pkg::CMD_ARB:      op = hsa_pkg::OP_ARB;
         default:               op = hsa_pkg::OP_NONE;
      endcase
      return op;
   endfunction

   assign busy = valid_ff && qstat.full;
   assign push = valid_ff && !qstat.full;
   assign take = start && !busy;

   // holding stage in front of the queue
   always_comb begin
      valid_in = take || (valid_ff && !push);
      item_in  = item_ff;
      if (take) begin
         item_in.op        = decode(req_data.cmd);
         item_in.source_id = req_data.source_id;
         item_in.flag      = req_data.flag;
         item_in.prio      = req_data.priority_req;
         item_in.now       = req_data.now_tick;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign push_item = item_ff;

endmodule

// ===== hdl/hsa_back.sv =====
module hsa_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   input  hsa_pkg::qstat_type qstat,
   input  hsa_pkg::item_type  pop_item,
   output logic               pop,
   output logic               rsp_valid,
   output hsa_pkg::rsp_type   rsp_data
);

   localparam int N  = hsa_pkg::NUM_SOURCES;
   localparam int SW = hsa_pkg::SLOT_W;
   localparam int CW = hsa_pkg::CNT_W;

   logic [31:0] silence_ff;
   logic [6:0]  threshold_ff, penalty_ff, hmax_ff;

   hsa_pkg::entry_type tbl_ff [N];

   hsa_pkg::state_type state_ff, state_in;
   hsa_pkg::item_type  item_ff, item_in;
   logic [CW-1:0]      used_ff, used_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [SW-1:0]      slot_ff, slot_in;
   logic               found_ff, found_in;
   logic [3:0]         owner_ff, owner_in;
   logic [3:0]         old_owner_ff, old_owner_in;
   logic [3:0]         best_ff, best_in;
   logic [7:0]         top_ff, top_in;
   logic [15:0]        mig_ff, mig_in;
   logic               acc_ff, acc_in;

   logic [SW-1:0]      rd_addr;
   hsa_pkg::entry_type rd;
   logic               wr_en;
   logic [SW-1:0]      wr_addr;
   hsa_pkg::entry_type wr_rec;
   logic               walk_end;
   logic               can_add;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         silence_ff   <= hsa_pkg::SILENCE_RESET;
         threshold_ff <= hsa_pkg::THRESHOLD_RESET;
         penalty_ff   <= hsa_pkg::PENALTY_RESET;
         hmax_ff      <= hsa_pkg::HMAX_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            hsa_pkg::CSR_SILENCE:   silence_ff   <= csr_wdata;
            hsa_pkg::CSR_THRESHOLD: threshold_ff <= csr_wdata[6:0];
            hsa_pkg::CSR_PENALTY:   penalty_ff   <= csr_wdata[6:0];
            hsa_pkg::CSR_HMAX:      hmax_ff      <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   assign rd_addr  = (state_ff == hsa_pkg::ST_WALK) ? idx_ff[SW-1:0] : slot_ff;
   assign rd       = tbl_ff[rd_addr];
   assign walk_end = (idx_ff == used_ff);
   assign can_add  = (item_ff.source_id != 4'd0) && (used_ff < CW'(N));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hsa_pkg::ST_IDLE:  if (!qstat.empty) state_in = hsa_pkg::ST_WALK;
         hsa_pkg::ST_WALK:  if (walk_end) state_in = hsa_pkg::ST_APPLY;
         hsa_pkg::ST_APPLY: state_in = hsa_pkg::ST_DONE;
         hsa_pkg::ST_DONE:  state_in = hsa_pkg::ST_IDLE;
         default:           state_in = hsa_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      pop       = (state_ff == hsa_pkg::ST_IDLE) && !qstat.empty;
      rsp_valid = (state_ff == hsa_pkg::ST_DONE);
   end

   // table walk and command execution
   always_comb begin
      item_in      = item_ff;
      used_in      = used_ff;
      idx_in       = idx_ff;
      slot_in      = slot_ff;
      found_in     = found_ff;
      owner_in     = owner_ff;
      old_owner_in = old_owner_ff;
      best_in      = best_ff;
      top_in       = top_ff;
      mig_in       = mig_ff;
      acc_in       = acc_ff;
      wr_en        = 1'b0;
      wr_addr      = slot_ff;
      wr_rec       = rd;
      case (state_ff)
         hsa_pkg::ST_IDLE: begin
            if (!qstat.empty) begin
               item_in      = pop_item;
               old_owner_in = owner_ff;
               idx_in       = '0;
               found_in     = 1'b0;
               best_in      = '0;
               top_in       = '0;
               acc_in       = 1'b0;
            end
         end
         hsa_pkg::ST_WALK: begin
            if (!walk_end) begin
               // id lookup, first match wins
               if (!found_ff && item_ff.source_id != 4'd0 && rd.id == item_ff.source_id) begin
                  found_in = 1'b1;
                  slot_in  = idx_ff[SW-1:0];
               end
               // classify this slot on arbitrate
               if (item_ff.op == hsa_pkg::OP_ARB) begin
                  wr_en   = 1'b1;
                  wr_addr = idx_ff[SW-1:0];
                  wr_rec.elig = 1'b0;
                  if (!rd.init || !rd.conn) begin
                  end else if (rd.count == 16'd0) begin
                  end else if (rd.health < threshold_ff) begin
                  end else if (rd.tick != 32'd0 && (item_ff.now - rd.tick) >= silence_ff) begin
                     wr_rec.recv = 1'b0;
                  end else begin
                     wr_rec.elig = 1'b1;
                     wr_rec.recv = 1'b1;
                  end
                  if (wr_rec.elig && rd.prio > top_ff) begin
                     top_in  = rd.prio;
                     best_in = rd.id;
                  end
               end
               idx_in = idx_ff + 1'b1;
            end
         end
         hsa_pkg::ST_APPLY: begin
            case (item_ff.op)
               hsa_pkg::OP_REG: begin
                  wr_rec.id     = item_ff.source_id;
                  wr_rec.prio   = item_ff.prio;
                  wr_rec.health = hmax_ff;
                  wr_rec.count  = '0;
                  wr_rec.conn   = 1'b0;
                  wr_rec.init   = item_ff.flag;
                  wr_rec.recv   = 1'b0;
                  wr_rec.elig   = 1'b0;
                  wr_rec.tick   = '0;
                  if (found_ff) begin
                     wr_en  = 1'b1;
                     acc_in = 1'b1;
                  end else if (can_add) begin
                     wr_en   = 1'b1;
                     wr_addr = used_ff[SW-1:0];
                     used_in = used_ff + 1'b1;
                     acc_in  = 1'b1;
                  end
               end
               hsa_pkg::OP_CONN: begin
                  if (found_ff) begin
                     wr_en  = 1'b1;
                     acc_in = 1'b1;
                     if (item_ff.flag) begin
                        wr_rec.conn = 1'b1;
                     end else begin
                        wr_rec.conn = 1'b0;
                        wr_rec.elig = 1'b0;
                        wr_rec.recv = 1'b0;
                        if (owner_ff == item_ff.source_id) owner_in = '0;
                     end
                  end
               end
               hsa_pkg::OP_PARSE: begin
                  if (found_ff) begin
                     wr_en  = 1'b1;
                     acc_in = 1'b1;
                     if (item_ff.flag) begin
                        if (rd.count != hsa_pkg::COUNT_MAX) wr_rec.count = rd.count + 1'b1;
                        wr_rec.recv = 1'b1;
                        if (rd.health < hmax_ff) wr_rec.health = rd.health + 1'b1;
                     end else if (rd.health > penalty_ff) begin
                        wr_rec.health = rd.health - penalty_ff;
                     end
                  end
               end
               hsa_pkg::OP_EVENT: begin
                  owner_in = item_ff.source_id;
                  if (found_ff) begin
                     wr_en  = 1'b1;
                     acc_in = 1'b1;
                     wr_rec.tick = item_ff.now;
                     if (rd.count != hsa_pkg::COUNT_MAX) wr_rec.count = rd.count + 1'b1;
                     wr_rec.recv = 1'b1;
                     wr_rec.conn = 1'b1;
                     wr_rec.init = 1'b1;
                  end else if (can_add) begin
                     wr_en         = 1'b1;
                     wr_addr       = used_ff[SW-1:0];
                     used_in       = used_ff + 1'b1;
                     acc_in        = 1'b1;
                     wr_rec.id     = item_ff.source_id;
                     wr_rec.prio   = item_ff.prio;
                     wr_rec.health = hmax_ff;
                     wr_rec.count  = 16'd1;
                     wr_rec.conn   = 1'b1;
                     wr_rec.init   = 1'b1;
                     wr_rec.recv   = 1'b1;
                     wr_rec.elig   = 1'b0;
                     wr_rec.tick   = item_ff.now;
                  end
               end
               hsa_pkg::OP_ARB: begin
                  acc_in = 1'b1;
                  if (best_ff != 4'd0 && best_ff != owner_ff) begin
                     if (owner_ff != 4'd0 && mig_ff != hsa_pkg::COUNT_MAX) mig_in = mig_ff + 1'b1;
                     owner_in = best_ff;
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hsa_pkg::ST_IDLE;
         used_ff  <= '0;
         owner_ff <= '0;
         mig_ff   <= '0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         owner_ff <= owner_in;
         mig_ff   <= mig_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      idx_ff       <= idx_in;
      slot_ff      <= slot_in;
      found_ff     <= found_in;
      old_owner_ff <= old_owner_in;
      best_ff      <= best_in;
      top_ff       <= top_in;
      acc_ff       <= acc_in;
   end

   // entry table
   always_ff @(posedge clock) begin
      if (wr_en) begin
         tbl_ff[wr_addr] <= wr_rec;
      end
   end

   // result assembly
   always_comb begin
      rsp_data.owner           = owner_ff;
      rsp_data.owner_changed   = (owner_ff != old_owner_ff);
      rsp_data.migration_count = mig_ff;
      rsp_data.entry_count     = 4'(used_ff);
      rsp_data.accepted        = acc_ff;
      rsp_data.eligible_mask   = '0;
      for (int i = 0; i < hsa_pkg::MASK_W; i++) begin
         if (i < N) begin
            rsp_data.eligible_mask[i] = tbl_ff[i % N].elig && (CW'(i) < used_ff);
         end
      end
   end

endmodule

// ===== hdl/health_scored_source_arbiter_core.sv =====
// health scored source arbiter
// keeps a table of sources with health, priority and silence tracking and
// picks an owner among the eligible ones
// request channel: a command transfers when start is high and busy is low;
// a two-entry queue sits between the decode stage and the execution engine,
// so busy rises only when both are full
// response channel: exactly one result per command, shown on rsp_data for
// one cycle with rsp_valid high; the receiver cannot hold it off
// flow: a command passes the decode stage and the queue, then a walk
// over the used table slots for the lookup or classify, then apply and
// result; the engine pops the next command only after the result of the
// last one, and the single-port walk over up to eight slots sets the rate
// csr port: csr_we writes csr_wdata into register csr_index at once;
// write only while no command is in flight
// reset (synchronous, active high) empties the table and queue, clears the
// owner and migration count and loads register defaults
module health_scored_source_arbiter_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  hsa_pkg::req_type req_data,
   output logic             rsp_valid,
   output hsa_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_wdata
);

   hsa_pkg::qstat_type qstat;
   hsa_pkg::item_type  push_item, pop_item;
   logic               push, pop;

   hsa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .qstat     (qstat),
      .push      (push),
      .push_item (push_item)
   );

   hsa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .stat      (qstat)
   );

   hsa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .qstat     (qstat),
      .pop_item  (pop_item),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hdl/hsa_checker.sv =====
module hsa_checker (
   input logic             clock,
   input logic             reset,
   input logic             busy,
   input logic             rsp_valid,
   input hsa_pkg::rsp_type rsp_data
);

   logic [15:0] last_mig_ff;

   // migration count of the previous result
   always_ff @(posedge clock) begin
      if (reset) begin
         last_mig_ff <= '0;
      end else if (rsp_valid) begin
         last_mig_ff <= rsp_data.migration_count;
      end
   end

   // reset leaves the front empty
   assert property (@(posedge clock) reset |=> !busy && !rsp_valid)
      else $error("busy or response right after reset");

   // the engine returns to idle after each result, so strobes never touch
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("back to back response strobes");

   // the table never reports more sources than it holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.entry_count <= 4'(hsa_pkg::NUM_SOURCES))
      else $error("entry count beyond table size");

   // the migration count never goes down between results
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.migration_count >= last_mig_ff)
      else $error("migration count went down");

endmodule

bind health_scored_source_arbiter_core hsa_checker u_hsa_checker (
   .clock     (clock),
   .reset     (reset),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
